/* src/swr_pkg.sv */
// Shared types and constants for the sliding-window RMS block.
// Used by swr_ctrl, swr_dpath, sliding_window_rms and the testbench; no dependencies.
package swr_pkg;

  localparam int SAMPLE_W   = 16;             // Q1.15 sample
  localparam int SQ_W       = 2 * SAMPLE_W;   // product of two magnitudes
  localparam int QUO_W      = SQ_W - 1;       // mean of squares is at most 2^30
  localparam int ROOT_W     = 16;             // root of a QUO_W-bit value
  localparam int RAD_W      = 2 * ROOT_W;     // radicand, two bits per root step
  localparam int SREM_W     = ROOT_W + 3;     // partial remainder of the root
  localparam int WIN_W      = 11;
  localparam logic [WIN_W-1:0] WIN_RESET = 11'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_in_record;
  } swr_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rms_value;
    logic              record_end;
  } swr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_NEW,
    ST_SQ_OLD,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_DONE
  } swr_state_t;

  typedef struct packed {
    logic accept;     // capture word, read leaving sample
    logic sq_new;     // square the new sample
    logic sq_old;     // add new square, square the leaving sample
    logic acc;        // drop leaving square or count up, store sample
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;   // move result into the output register
  } swr_cmd_t;

  typedef struct packed {
    logic win_zero;
  } swr_sts_t;

endpackage

/* src/swr_ctrl.sv */
// Sequencer for the sliding-window RMS block: walks one word through
// update, divide and square root. Uses swr_pkg.
module swr_ctrl import swr_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  swr_sts_t sts,
  output swr_cmd_t cmd
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = 30 + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  swr_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.win_zero ? ST_DONE : ST_SQ_NEW;
        end
      end
      ST_SQ_NEW: begin
        cmd.sq_new = 1'b1;
        state_nxt  = ST_SQ_OLD;
      end
      ST_SQ_OLD: begin
        cmd.sq_old = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_SQRT_LOAD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SQRT_LOAD: begin
        cmd.sqrt_load = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == SQRT_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // one word in flight: the cycle after an accept takes nothing new
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten before it was taken");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result presented outside the done state");

endmodule

/* src/swr_dpath.sv */
// Datapath for the sliding-window RMS block: delay line, square and sum,
// bit-serial divider, digit-by-digit square root, output register. Uses swr_pkg.
module swr_dpath import swr_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  swr_in_t          in_data,
  output swr_out_t         out_data,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_data,
  input  swr_cmd_t         cmd,
  output swr_sts_t         sts
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = 30 + CNT_W;
  localparam logic [CNT_W-1:0] MAXW_C  = CNT_W'(MAX_WINDOW);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(MAX_WINDOW - 1);
  localparam logic [SUM_W-1:0] QUO_LIM = SUM_W'(64'd1 << (SQ_W - 2));
  localparam logic [ROOT_W:0]  RMS_LIM = (ROOT_W + 1)'(32'd1 << (ROOT_W - 1));

  // configuration and running state
  logic [WIN_W-1:0] window_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] ptr_r;

  // per-word registers
  logic [SAMPLE_W-1:0] smp_r;
  logic [SAMPLE_W-1:0] rd_r;
  logic                last_r;
  logic                zero_r;
  logic                full_r;
  logic [SQ_W-1:0]     sq_r;

  // divider and root
  logic [SUM_W-1:0]  dq_r;
  logic [CNT_W:0]    drem_r;
  logic [RAD_W-1:0]  rad_r;
  logic [SREM_W-1:0] srem_r;
  logic [ROOT_W-1:0] root_r;

  swr_out_t out_r;

  logic [SAMPLE_W-1:0] hist_mem [MAX_WINDOW];

  // saturated window and the index of the sample that leaves it
  logic             win_sat;
  logic [CNT_W-1:0] w_eff;
  logic [31:0]      idx_sum;
  logic [PTR_W-1:0] old_idx;

  always_comb begin
    win_sat = (32'(window_r) > 32'(MAX_WINDOW));
    w_eff   = win_sat ? MAXW_C : CNT_W'(window_r);
    idx_sum = 32'(ptr_r) + 32'(MAX_WINDOW) - 32'(w_eff);
    if (idx_sum >= 32'(MAX_WINDOW)) begin
      old_idx = PTR_W'(idx_sum - 32'(MAX_WINDOW));
    end else begin
      old_idx = PTR_W'(idx_sum);
    end
  end

  assign sts.win_zero = (window_r == '0);

  // squarer, shared by new and leaving sample
  logic [SAMPLE_W-1:0] sq_in;
  logic [SAMPLE_W-1:0] sq_mag;

  always_comb begin
    sq_in  = cmd.sq_new ? smp_r : rd_r;
    sq_mag = sq_in[SAMPLE_W-1] ? (~sq_in + 1'b1) : sq_in;
  end

  // divider step: restoring, one quotient bit per cycle
  logic [CNT_W:0] drem_sh;
  logic [CNT_W:0] drem_dif;
  logic           dq_bit;

  always_comb begin
    drem_sh  = {drem_r[CNT_W-1:0], dq_r[SUM_W-1]};
    drem_dif = drem_sh - {1'b0, cnt_r};
    dq_bit   = (drem_sh >= {1'b0, cnt_r});
  end

  // root step: bring down two radicand bits, try root*4+1
  logic [SREM_W-1:0] srem_sh;
  logic [SREM_W-1:0] trial;
  logic              root_bit;

  always_comb begin
    srem_sh  = {srem_r[SREM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
    trial    = SREM_W'({root_r, 2'b01});
    root_bit = (srem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
      sum_r    <= '0;
      cnt_r    <= '0;
      ptr_r    <= '0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_data;
        sum_r    <= '0;
        cnt_r    <= '0;
      end else if (cmd.sq_old) begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end else if (cmd.acc) begin
        if (full_r) begin
          sum_r <= sum_r - SUM_W'(sq_r);
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
        ptr_r <= (ptr_r == PTR_END) ? '0 : ptr_r + 1'b1;
      end else if (cmd.out_load && last_r) begin
        // record ends: restart the window empty
        sum_r <= '0;
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= hist_mem[old_idx];
    end
    if (cmd.acc) begin
      hist_mem[ptr_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r  <= in_data.sample_value;
      last_r <= in_data.last_in_record;
      zero_r <= sts.win_zero;
      full_r <= (cnt_r >= w_eff);
    end
    if (cmd.sq_new || cmd.sq_old) begin
      sq_r <= sq_mag * sq_mag;
    end
    if (cmd.div_load) begin
      dq_r   <= sum_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r   <= {dq_r[SUM_W-2:0], dq_bit};
      drem_r <= dq_bit ? drem_dif : drem_sh;
    end
    if (cmd.sqrt_load) begin
      rad_r  <= RAD_W'(dq_r[QUO_W-1:0]);
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      srem_r <= root_bit ? (srem_sh - trial) : srem_sh;
      root_r <= {root_r[ROOT_W-2:0], root_bit};
    end
    if (cmd.out_load) begin
      out_r.rms_value  <= zero_r ? '0 : root_r;
      out_r.record_end <= last_r;
    end
  end

  assign out_data = out_r;

  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= w_eff)
    else $error("sample count exceeds the window");

  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_load |-> dq_r <= QUO_LIM)
    else $error("mean of squares above full scale");

  a_rms_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && !zero_r |-> {1'b0, root_r} <= RMS_LIM)
    else $error("root above full scale");

endmodule

/* src/sliding_window_rms.sv */
// Sliding-window RMS of Q1.15 samples: one result word per input word,
// floor(sqrt(floor(sum of squares / samples in window))). Uses swr_pkg, swr_ctrl, swr_dpath.
//
// One word is in work at a time: the block does not take a new word until the
// last one has been loaded into the result register. A word passes through the
// square-and-sum update around the delay-line memory in three steps, a load step
// and one quotient bit per cycle in the restoring divider, a load step and one
// root bit per cycle in the 16-step square-root unit, and a load of the result
// register. With a window of zero a word goes from accept straight to the result
// load, and the result is zero. A result that cannot be loaded because the
// previous one is still stalled holds the block until that one is taken. The
// result register lets the next word be accepted while a result is still stalled.
// Writing the window register (cfg_we) restarts the window empty; the delay line
// needs no clearing pass, since an entry is used only after it has been written.
module sliding_window_rms import swr_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  swr_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output swr_out_t         out_data,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_data
);

  swr_cmd_t cmd;
  swr_sts_t sts;

  swr_ctrl #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swr_dpath #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .out_data(out_data),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

/* tb/rms_monitor.sv */
// Channel monitor for sliding_window_rms: tracks the window state, predicts each RMS word
// and compares it with the block's output. Depends on swr_pkg.
module rms_monitor import swr_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  swr_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  swr_out_t         out_data,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_data,
  output int               fail_count,
  output int               words_waiting,
  output int               results_checked
);

  logic [SAMPLE_W-1:0] delay_line [MAX_WINDOW];
  logic [40:0]         sq_sum;
  logic [WIN_W-1:0]    seen;
  logic [WIN_W-1:0]    window;
  int                  head;
  swr_out_t            rms_expected [$];
  int                  errors;
  int                  checked;

  function automatic logic [31:0] square_mag(input logic signed [SAMPLE_W-1:0] s);
    longint v;
    v = s;
    return 32'(v * v);
  endfunction

  function automatic logic [15:0] floor_root(input logic [40:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= 64'(x)) r = t;
    end
    return r[15:0];
  endfunction

  task automatic report(input string field, input longint unsigned want,
                        input longint unsigned got);
    errors++;
    $display("mismatch at result %0d (t=%0t): %s expected %0d, got %0d",
             checked, $time, field, want, got);
  endtask

  task automatic predict_word(input swr_in_t w);
    int       span;
    int       old_slot;
    swr_out_t e;
    span = (window > MAX_WINDOW) ? MAX_WINDOW : int'(window);
    e.rms_value  = '0;
    e.record_end = w.last_in_record;
    if (span != 0) begin
      // drop the leaving square once the window is full, else count up
      if (int'(seen) >= span) begin
        old_slot = (head + MAX_WINDOW - span) % MAX_WINDOW;
        sq_sum   = sq_sum - square_mag(delay_line[old_slot]);
      end else begin
        seen = seen + 1'b1;
      end
      delay_line[head] = w.sample_value;
      sq_sum = sq_sum + square_mag(w.sample_value);
      head   = (head + 1) % MAX_WINDOW;
      e.rms_value = floor_root(sq_sum / seen);
    end
    if (w.last_in_record) begin
      sq_sum = '0;
      seen   = '0;
    end
    rms_expected.push_back(e);
  endtask

  task automatic check_word(input swr_out_t got);
    swr_out_t e;
    checked++;
    if (rms_expected.size() == 0) begin
      report("unexpected word, rms_value", 0, got.rms_value);
    end else begin
      e = rms_expected.pop_front();
      if (got.rms_value !== e.rms_value) report("rms_value", e.rms_value, got.rms_value);
      if (got.record_end !== e.record_end) report("record_end", e.record_end, got.record_end);
    end
  endtask

  initial begin
    errors  = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      window = WIN_RESET;
      sq_sum = '0;
      seen   = '0;
      head   = 0;
      rms_expected.delete();
    end else begin
      // a register write restarts the window empty; delay line and pointer stay
      if (cfg_we) begin
        window = cfg_data;
        sq_sum = '0;
        seen   = '0;
      end
      if (out_valid && !out_stall) check_word(out_data);
      if (in_valid && !in_stall) predict_word(in_data);
    end
    words_waiting   <= rms_expected.size();
    fail_count      <= errors;
    results_checked <= checked;
  end

endmodule

/* tb/tb.sv */
// Top of the sliding_window_rms testbench: clock, reset, stimulus, output stall and verdict.
// Depends on swr_pkg, sliding_window_rms and rms_monitor.
module tb;
  import swr_pkg::*;

  localparam int MAX_WINDOW = 1024;
  localparam int IDLE_LIMIT = 3000;
  localparam int WORD_TARGET = 1620;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  swr_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  swr_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [WIN_W-1:0] cfg_data = '0;

  int fail_count;
  int words_waiting;
  int results_checked;
  int words_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int hold = 0;
  bit steady = 1'b1;

  always #5 clk = ~clk;

  sliding_window_rms #(.MAX_WINDOW(MAX_WINDOW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  rms_monitor #(.MAX_WINDOW(MAX_WINDOW)) u_rms_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .words_waiting   (words_waiting),
    .results_checked (results_checked)
  );

  // draw a stall length after each taken result word
  always @(posedge clk) begin
    if (!rst_n) begin
      hold = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      hold = steady ? 0 : $urandom_range(0, 5);
      out_stall <= (hold != 0);
    end else if (hold > 0) begin
      hold = hold - 1;
      out_stall <= (hold != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int      gap;
    swr_in_t w;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.sample_value   = s;
    w.last_in_record = last;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // hold the sender until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input int win);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= WIN_W'(win);
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings_used++;
  endtask

  // last_odds of zero flags only the final word of the phase
  task automatic run_phase(input int win, input int count, input int last_odds);
    logic last;
    steady = ($urandom_range(0, 3) == 0);
    write_window(win);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 79) == 0) drain();
      if (last_odds == 0) last = (i == count - 1);
      else last = ($urandom_range(1, last_odds) == 1);
      send_word(rand_sample(), last);
    end
  endtask

  initial begin
    int win;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of one straight out of reset
    steady = 1'b1;
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sd0, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b1);

    // full-scale window, then a write that lands mid-record
    write_window(3);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sd12345, 1'b1);
    send_word(-16'sd12345, 1'b0);
    send_word(16'sd100, 1'b0);

    // zero window gives zero but still echoes the flag
    write_window(0);
    send_word(16'sh7FFF, 1'b0);
    send_word(-16'sd5, 1'b1);
    send_word(16'sh8000, 1'b0);

    write_window(2);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sd0, 1'b1);

    // oversized window saturates; one long record wraps the full delay line
    run_phase(2047, MAX_WINDOW + 40, 0);
    run_phase(MAX_WINDOW, 60, 0);

    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 7))
        0:       win = 0;
        1:       win = 1;
        2:       win = $urandom_range(2, 4);
        3:       win = MAX_WINDOW;
        4:       win = 2047;
        5:       win = $urandom_range(MAX_WINDOW + 1, 2046);
        6:       win = $urandom_range(5, 40);
        default: win = $urandom_range(1, 2047);
      endcase
      run_phase(win, $urandom_range(10, 60), $urandom_range(2, 25));
    end

    drain();
    repeat (70) @(posedge clk);
    $display("Sent %0d sample words across %0d window settings; %0d RMS words compared.",
             words_sent, settings_used, results_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
